[sv/rtnh_pkg.sv]
// Shared types, constants and the micro-program for the nearest ray/triangle hit block.
// Used by rtnh_ctrl, rtnh_datapath, rtnh_div and ray_triangle_nearest_hit.
// No dependencies.
`default_nettype none

package rtnh_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam int COORD_W   = 32;
    localparam int DIR_W     = 18;
    localparam int EDGE_W    = 33;
    localparam int DIST_W    = 31;
    localparam int DIGIT_W   = 17;
    localparam int PC_W      = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W = 9 * COORD_W;
    localparam int OUT_DATA_W = 128;
    localparam int DIV_STEPS = 31;
    localparam int DCNT_W    = 5;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;

    localparam logic signed [EDGE_W-1:0] K_TOL   = 33'sd10000;
    localparam logic signed [EDGE_W-1:0] K_LIM   = 33'sd10001;
    localparam logic signed [EDGE_W-1:0] K_MIN_T = 33'sd100000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV,
        ST_FIN
    } ctrl_state_t;

    typedef enum logic [2:0] {
        UOP_MUL,
        UOP_WR,
        UOP_NORM,
        UOP_CMP,
        UOP_DIV,
        UOP_UPD
    } uop_kind_t;

    typedef enum logic [4:0] {
        A_E2X, A_E2Y, A_E2Z,
        A_TVX, A_TVY, A_TVZ,
        A_P0, A_P1, A_P2,
        A_Q0, A_Q1, A_Q2,
        A_DET, A_UN, A_VN, A_TN,
        A_UNVN, A_T
    } a_sel_t;

    typedef enum logic [3:0] {
        B_DX, B_DY, B_DZ,
        B_E1X, B_E1Y, B_E1Z,
        B_E2X, B_E2Y, B_E2Z,
        B_TVX, B_TVY, B_TVZ,
        B_KTOL, B_KLIM, B_KMINT
    } b_sel_t;

    typedef enum logic [4:0] {
        D_NONE,
        D_P0, D_P1, D_P2,
        D_Q0, D_Q1, D_Q2,
        D_DET, D_UN, D_VN, D_TN,
        D_CUN, D_CLIM, D_CVN, D_CUV, D_CTN,
        D_HX, D_HY, D_HZ
    } dst_t;

    typedef struct packed {
        uop_kind_t kind;
        a_sel_t    a_sel;
        b_sel_t    b_sel;
        dst_t      dst;
        logic      clr;
        logic      neg;
    } uop_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic digit;
        uop_t uop;
        logic div_step;
        logic emit;
    } rtnh_cmd_t;

    typedef struct packed {
        logic reject;
        logic out_busy;
    } rtnh_status_t;

    localparam logic [PC_W-1:0] PC_LAST = 6'd53;

    function automatic uop_t u_mul(input a_sel_t a, input b_sel_t b, input logic clr,
                                   input logic neg);
        uop_t u;
        u.kind  = UOP_MUL;
        u.a_sel = a;
        u.b_sel = b;
        u.dst   = D_NONE;
        u.clr   = clr;
        u.neg   = neg;
        return u;
    endfunction

    function automatic uop_t u_wr(input dst_t d);
        uop_t u;
        u       = u_mul(A_E2X, B_DX, 1'b0, 1'b0);
        u.kind  = UOP_WR;
        u.dst   = d;
        return u;
    endfunction

    function automatic uop_t u_ctl(input uop_kind_t k);
        uop_t u;
        u      = u_mul(A_E2X, B_DX, 1'b0, 1'b0);
        u.kind = k;
        return u;
    endfunction

    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            6'd0:  u = u_mul(A_E2Z, B_DY, 1'b1, 1'b0);
            6'd1:  u = u_mul(A_E2Y, B_DZ, 1'b0, 1'b1);
            6'd2:  u = u_wr(D_P0);
            6'd3:  u = u_mul(A_E2X, B_DZ, 1'b1, 1'b0);
            6'd4:  u = u_mul(A_E2Z, B_DX, 1'b0, 1'b1);
            6'd5:  u = u_wr(D_P1);
            6'd6:  u = u_mul(A_E2Y, B_DX, 1'b1, 1'b0);
            6'd7:  u = u_mul(A_E2X, B_DY, 1'b0, 1'b1);
            6'd8:  u = u_wr(D_P2);
            6'd9:  u = u_mul(A_TVY, B_E1Z, 1'b1, 1'b0);
            6'd10: u = u_mul(A_TVZ, B_E1Y, 1'b0, 1'b1);
            6'd11: u = u_wr(D_Q0);
            6'd12: u = u_mul(A_TVZ, B_E1X, 1'b1, 1'b0);
            6'd13: u = u_mul(A_TVX, B_E1Z, 1'b0, 1'b1);
            6'd14: u = u_wr(D_Q1);
            6'd15: u = u_mul(A_TVX, B_E1Y, 1'b1, 1'b0);
            6'd16: u = u_mul(A_TVY, B_E1X, 1'b0, 1'b1);
            6'd17: u = u_wr(D_Q2);
            6'd18: u = u_mul(A_P0, B_E1X, 1'b1, 1'b0);
            6'd19: u = u_mul(A_P1, B_E1Y, 1'b0, 1'b0);
            6'd20: u = u_mul(A_P2, B_E1Z, 1'b0, 1'b0);
            6'd21: u = u_wr(D_DET);
            6'd22: u = u_mul(A_P0, B_TVX, 1'b1, 1'b0);
            6'd23: u = u_mul(A_P1, B_TVY, 1'b0, 1'b0);
            6'd24: u = u_mul(A_P2, B_TVZ, 1'b0, 1'b0);
            6'd25: u = u_wr(D_UN);
            6'd26: u = u_mul(A_Q0, B_DX, 1'b1, 1'b0);
            6'd27: u = u_mul(A_Q1, B_DY, 1'b0, 1'b0);
            6'd28: u = u_mul(A_Q2, B_DZ, 1'b0, 1'b0);
            6'd29: u = u_wr(D_VN);
            6'd30: u = u_mul(A_Q0, B_E2X, 1'b1, 1'b0);
            6'd31: u = u_mul(A_Q1, B_E2Y, 1'b0, 1'b0);
            6'd32: u = u_mul(A_Q2, B_E2Z, 1'b0, 1'b0);
            6'd33: u = u_wr(D_TN);
            6'd34: u = u_ctl(UOP_NORM);
            6'd35: u = u_mul(A_UN, B_KTOL, 1'b1, 1'b0);
            6'd36: u = u_wr(D_CUN);
            6'd37: u = u_mul(A_DET, B_KLIM, 1'b1, 1'b0);
            6'd38: u = u_wr(D_CLIM);
            6'd39: u = u_mul(A_VN, B_KTOL, 1'b1, 1'b0);
            6'd40: u = u_wr(D_CVN);
            6'd41: u = u_mul(A_UNVN, B_KTOL, 1'b1, 1'b0);
            6'd42: u = u_wr(D_CUV);
            6'd43: u = u_mul(A_TN, B_KMINT, 1'b1, 1'b0);
            6'd44: u = u_wr(D_CTN);
            6'd45: u = u_ctl(UOP_CMP);
            6'd46: u = u_ctl(UOP_DIV);
            6'd47: u = u_mul(A_T, B_DX, 1'b1, 1'b0);
            6'd48: u = u_wr(D_HX);
            6'd49: u = u_mul(A_T, B_DY, 1'b1, 1'b0);
            6'd50: u = u_wr(D_HY);
            6'd51: u = u_mul(A_T, B_DZ, 1'b1, 1'b0);
            6'd52: u = u_wr(D_HZ);
            default: u = u_ctl(UOP_UPD);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

[sv/ray_triangle_nearest_hit.sv]
// Nearest ray/triangle hit, top level: ties the controller to the datapath.
// Depends on rtnh_pkg, rtnh_ctrl, rtnh_datapath and rtnh_div.
//
// Usage: write the ray origin and unit direction through cfg_we/cfg_index/cfg_data
// while the block is idle. Stream triangles on the s_axis side, one request each;
// tuser carries the skip flag, tlast marks the final triangle of a mesh. After the
// final triangle one result leaves on the m_axis side with the nearest hit.
// Sequence: a skipped triangle goes from the intake straight to the finish state.
// A tested triangle that is accepted passes the intake, 32 products on the shared
// multiplier (one 17-bit digit of the second operand per cycle), 18 write-back
// steps, 4 check/update steps, the one-bit-per-cycle divider and the finish
// state. A triangle rejected by the determinant or tolerance checks leaves
// earlier. A result is valid on m_axis the cycle after finish issues it.
// A new request is taken once the previous one is finished; a result waiting in
// the output register does not hold off requests until the next final triangle
// needs that register, then the block waits for m_axis_tready.
// Reset clears the ray registers to zero, drops the kept hit and empties the
// output register.
`default_nettype none

module ray_triangle_nearest_hit #(
    parameter int COORD_FRAC_BITS = rtnh_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [rtnh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rtnh_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
    // corner_c_x, corner_c_y, corner_c_z
    input  wire logic [rtnh_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // skip_triangle
    input  wire logic [0:0]                          s_axis_tuser,
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // hit_distance, hit_x, hit_y, hit_z, one zero pad bit
    output logic [rtnh_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    // hit_found
    output logic [0:0]                               m_axis_tuser
);
    import rtnh_pkg::*;

    rtnh_cmd_t    cmd;
    rtnh_status_t status;

    rtnh_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tlast  (s_axis_tlast),
        .skip          (s_axis_tuser[0]),
        .cmd           (cmd),
        .status        (status)
    );

    rtnh_datapath #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

[sv/rtnh_ctrl.sv]
// Controller for the nearest ray/triangle hit block: request intake, micro-program
// sequencing, divider loop and result hand-off. Depends on rtnh_pkg.
`default_nettype none

module rtnh_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic                  s_axis_tlast,
    input  wire logic                  skip,
    output rtnh_pkg::rtnh_cmd_t        cmd,
    input  wire rtnh_pkg::rtnh_status_t status
);
    import rtnh_pkg::*;

    ctrl_state_t         state_reg, state_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic                digit_reg, digit_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic                last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            digit_reg <= 1'b0;
            dcnt_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            digit_reg <= digit_next;
            dcnt_reg  <= dcnt_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        digit_next    = digit_reg;
        dcnt_next     = dcnt_reg;
        last_next     = last_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        cmd.uop       = ucode(pc_reg);
        cmd.digit     = digit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    last_next  = s_axis_tlast;
                    pc_next    = '0;
                    digit_next = 1'b0;
                    state_next = skip ? ST_FIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.exec = 1'b1;
                case (cmd.uop.kind)
                    UOP_MUL:
                    begin
                        digit_next = ~digit_reg;
                        if (digit_reg)
                        begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    UOP_NORM, UOP_CMP:
                    begin
                        if (status.reject)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    UOP_DIV:
                    begin
                        dcnt_next  = '0;
                        pc_next    = pc_reg + 1'b1;
                        state_next = ST_DIV;
                    end
                    UOP_UPD:
                    begin
                        state_next = ST_FIN;
                    end
                    default:
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                endcase
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !status.out_busy)
        else $error("result issued while the output register is held");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> pc_reg <= PC_LAST)
        else $error("micro-program counter past the end");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while the previous one is in progress");
`endif

endmodule

`default_nettype wire

[sv/rtnh_div.sv]
// Bit-serial restoring divider for the ray parameter: t = floor(tn * 2^F / det),
// saturated to the distance maximum. Depends on rtnh_pkg.
`default_nettype none

module rtnh_div #(
    parameter int COORD_FRAC_BITS = rtnh_pkg::COORD_FRAC_BITS_DEF,
    parameter int VAL_W = 102 - 2 * COORD_FRAC_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          init,
    input  wire logic                          step,
    input  wire logic signed [VAL_W-1:0]       num,
    input  wire logic signed [VAL_W-1:0]       den,
    output logic [rtnh_pkg::DIST_W-1:0]        quot
);
    import rtnh_pkg::*;

    localparam int DW = VAL_W + 32;

    logic [DW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     dsh_reg, dsh_next;
    logic [DIST_W-1:0] qt_reg, qt_next;
    logic              sat_reg, sat_next;
    logic [DW-1:0]     num_ext, den_ext;

    assign num_ext = {{(DW - VAL_W){1'b0}}, num} << COORD_FRAC_BITS;
    assign den_ext = {{(DW - VAL_W){1'b0}}, den};

    always_comb
    begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        qt_next  = qt_reg;
        sat_next = sat_reg;
        if (init)
        begin
            rem_next = num_ext;
            dsh_next = den_ext << (DIST_W - 1);
            qt_next  = '0;
            sat_next = num_ext >= (den_ext << DIST_W);
        end
        else if (step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                qt_next  = {qt_reg[DIST_W-2:0], 1'b1};
            end
            else
            begin
                qt_next  = {qt_reg[DIST_W-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        qt_reg  <= qt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
        end
        else
        begin
            sat_reg <= sat_next;
        end
    end

    assign quot = sat_reg ? DIST_MAX : qt_reg;

endmodule

`default_nettype wire

[sv/rtnh_datapath.sv]
// Datapath for the nearest ray/triangle hit block: ray registers, edge vectors,
// shared multiply-accumulate unit, tolerance checks, nearest-hit state and result
// register. Depends on rtnh_pkg and rtnh_div.
`default_nettype none

module rtnh_datapath #(
    parameter int COORD_FRAC_BITS = rtnh_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [rtnh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rtnh_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [rtnh_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  wire rtnh_pkg::rtnh_cmd_t                 cmd,
    output rtnh_pkg::rtnh_status_t                   status,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [rtnh_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    output logic [0:0]                               m_axis_tuser
);
    import rtnh_pkg::*;

    localparam int F    = COORD_FRAC_BITS;
    localparam int PW   = 52 - F;
    localparam int QW   = 67 - F;
    localparam int VW   = 102 - 2 * F;
    localparam int AW   = 103 - 2 * F;
    localparam int PPW  = AW + DIGIT_W + 1;
    localparam int ACCW = PPW + DIGIT_W;

    localparam logic signed [ACCW-1:0] HIT_MAX = ACCW'(64'sh7FFF_FFFF);
    localparam logic signed [ACCW-1:0] HIT_MIN = ACCW'(-64'sh8000_0000);

    logic signed [COORD_W-1:0] org_x_reg, org_y_reg, org_z_reg;
    logic signed [DIR_W-1:0]   dir_x_reg, dir_y_reg, dir_z_reg;

    logic signed [EDGE_W-1:0] e1x_reg, e1y_reg, e1z_reg;
    logic signed [EDGE_W-1:0] e2x_reg, e2y_reg, e2z_reg;
    logic signed [EDGE_W-1:0] tvx_reg, tvy_reg, tvz_reg;
    logic signed [PW-1:0]     p0_reg, p1_reg, p2_reg;
    logic signed [QW-1:0]     q0_reg, q1_reg, q2_reg;
    logic signed [VW-1:0]     det_reg, un_reg, vn_reg, tn_reg;
    logic signed [ACCW-1:0]   cun_reg, clim_reg, cvn_reg, cuv_reg, ctn_reg;
    logic signed [COORD_W-1:0] hx_reg, hy_reg, hz_reg;
    logic signed [ACCW-1:0]   acc_reg, acc_next;

    logic [DIST_W-1:0]         best_dist_reg;
    logic signed [COORD_W-1:0] best_x_reg, best_y_reg, best_z_reg;
    logic                      any_hit_reg;

    logic                      out_valid_reg;
    logic                      out_found_reg;
    logic [DIST_W-1:0]         out_dist_reg;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg, out_z_reg;

    logic signed [COORD_W-1:0] cor [9];
    logic signed [AW-1:0]      a_val;
    logic signed [EDGE_W-1:0]  b_val;
    logic [EDGE_W-1:0]         b_mag;
    logic [DIGIT_W-1:0]        digit_val;
    logic signed [PPW-1:0]     pp;
    logic signed [ACCW-1:0]    pp_ext, acc_base;
    logic signed [ACCW-1:0]    shifted, hsum, det_ext, ndet;
    logic signed [COORD_W-1:0] org_sel, hit_sat;
    logic signed [VW:0]        unvn;
    logic [DIST_W-1:0]         t_val;
    logic                      is_mul, is_wr, is_norm, is_cmp, is_upd, cmp_fail;

    for (genvar i = 0; i < 9; i++)
    begin : g_corner
        assign cor[i] = s_axis_tdata[COORD_W*i +: COORD_W];
    end

    assign is_mul  = cmd.exec && (cmd.uop.kind == UOP_MUL);
    assign is_wr   = cmd.exec && (cmd.uop.kind == UOP_WR);
    assign is_norm = cmd.exec && (cmd.uop.kind == UOP_NORM);
    assign is_cmp  = cmd.exec && (cmd.uop.kind == UOP_CMP);
    assign is_upd  = cmd.exec && (cmd.uop.kind == UOP_UPD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            dir_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: org_x_reg <= cfg_data;
                CFG_ORIGIN_Y: org_y_reg <= cfg_data;
                CFG_ORIGIN_Z: org_z_reg <= cfg_data;
                CFG_DIR_X:    dir_x_reg <= cfg_data[DIR_W-1:0];
                CFG_DIR_Y:    dir_y_reg <= cfg_data[DIR_W-1:0];
                CFG_DIR_Z:    dir_z_reg <= cfg_data[DIR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e1x_reg <= EDGE_W'(cor[3]) - EDGE_W'(cor[0]);
            e1y_reg <= EDGE_W'(cor[4]) - EDGE_W'(cor[1]);
            e1z_reg <= EDGE_W'(cor[5]) - EDGE_W'(cor[2]);
            e2x_reg <= EDGE_W'(cor[6]) - EDGE_W'(cor[0]);
            e2y_reg <= EDGE_W'(cor[7]) - EDGE_W'(cor[1]);
            e2z_reg <= EDGE_W'(cor[8]) - EDGE_W'(cor[2]);
            tvx_reg <= EDGE_W'(org_x_reg) - EDGE_W'(cor[0]);
            tvy_reg <= EDGE_W'(org_y_reg) - EDGE_W'(cor[1]);
            tvz_reg <= EDGE_W'(org_z_reg) - EDGE_W'(cor[2]);
        end
    end

    assign unvn = VW'(un_reg) + VW'(vn_reg) + (VW + 1)'(0);

    always_comb
    begin
        case (cmd.uop.a_sel)
            A_E2X:   a_val = AW'(e2x_reg);
            A_E2Y:   a_val = AW'(e2y_reg);
            A_E2Z:   a_val = AW'(e2z_reg);
            A_TVX:   a_val = AW'(tvx_reg);
            A_TVY:   a_val = AW'(tvy_reg);
            A_TVZ:   a_val = AW'(tvz_reg);
            A_P0:    a_val = AW'(p0_reg);
            A_P1:    a_val = AW'(p1_reg);
            A_P2:    a_val = AW'(p2_reg);
            A_Q0:    a_val = AW'(q0_reg);
            A_Q1:    a_val = AW'(q1_reg);
            A_Q2:    a_val = AW'(q2_reg);
            A_DET:   a_val = AW'(det_reg);
            A_UN:    a_val = AW'(un_reg);
            A_VN:    a_val = AW'(vn_reg);
            A_TN:    a_val = AW'(tn_reg);
            A_UNVN:  a_val = AW'(unvn);
            A_T:     a_val = AW'($signed({1'b0, t_val}));
            default: a_val = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.uop.b_sel)
            B_DX:    b_val = EDGE_W'(dir_x_reg);
            B_DY:    b_val = EDGE_W'(dir_y_reg);
            B_DZ:    b_val = EDGE_W'(dir_z_reg);
            B_E1X:   b_val = e1x_reg;
            B_E1Y:   b_val = e1y_reg;
            B_E1Z:   b_val = e1z_reg;
            B_E2X:   b_val = e2x_reg;
            B_E2Y:   b_val = e2y_reg;
            B_E2Z:   b_val = e2z_reg;
            B_TVX:   b_val = tvx_reg;
            B_TVY:   b_val = tvy_reg;
            B_TVZ:   b_val = tvz_reg;
            B_KTOL:  b_val = K_TOL;
            B_KLIM:  b_val = K_LIM;
            B_KMINT: b_val = K_MIN_T;
            default: b_val = '0;
        endcase
    end

    assign b_mag     = b_val[EDGE_W-1] ? EDGE_W'(-b_val) : EDGE_W'(b_val);
    assign digit_val = cmd.digit ? {1'b0, b_mag[EDGE_W-1:DIGIT_W]} : b_mag[DIGIT_W-1:0];
    assign pp        = a_val * $signed({1'b0, digit_val});
    assign pp_ext    = cmd.digit ? (ACCW'(pp) <<< DIGIT_W) : ACCW'(pp);
    assign acc_base  = (cmd.uop.clr && !cmd.digit) ? '0 : acc_reg;
    assign acc_next  = (cmd.uop.neg ^ b_val[EDGE_W-1]) ? acc_base - pp_ext
                                                        : acc_base + pp_ext;

    always_ff @(posedge clk)
    begin
        if (is_mul)
        begin
            acc_reg <= acc_next;
        end
    end

    assign shifted = acc_reg >>> F;

    always_comb
    begin
        case (cmd.uop.dst)
            D_HY:    org_sel = org_y_reg;
            D_HZ:    org_sel = org_z_reg;
            default: org_sel = org_x_reg;
        endcase
    end

    assign hsum = ACCW'(org_sel) + shifted;

    always_comb
    begin
        if (hsum > HIT_MAX)
        begin
            hit_sat = HIT_MAX[COORD_W-1:0];
        end
        else if (hsum < HIT_MIN)
        begin
            hit_sat = HIT_MIN[COORD_W-1:0];
        end
        else
        begin
            hit_sat = hsum[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_wr)
        begin
            case (cmd.uop.dst)
                D_P0:   p0_reg   <= shifted[PW-1:0];
                D_P1:   p1_reg   <= shifted[PW-1:0];
                D_P2:   p2_reg   <= shifted[PW-1:0];
                D_Q0:   q0_reg   <= shifted[QW-1:0];
                D_Q1:   q1_reg   <= shifted[QW-1:0];
                D_Q2:   q2_reg   <= shifted[QW-1:0];
                D_DET:  det_reg  <= shifted[VW-1:0];
                D_UN:   un_reg   <= shifted[VW-1:0];
                D_VN:   vn_reg   <= shifted[VW-1:0];
                D_TN:   tn_reg   <= shifted[VW-1:0];
                D_CUN:  cun_reg  <= acc_reg;
                D_CLIM: clim_reg <= acc_reg;
                D_CVN:  cvn_reg  <= acc_reg;
                D_CUV:  cuv_reg  <= acc_reg;
                D_CTN:  ctn_reg  <= acc_reg;
                D_HX:   hx_reg   <= hit_sat;
                D_HY:   hy_reg   <= hit_sat;
                D_HZ:   hz_reg   <= hit_sat;
                default:
                begin
                end
            endcase
        end
        else if (is_norm && det_reg[VW-1])
        begin
            det_reg <= -det_reg;
            un_reg  <= -un_reg;
            vn_reg  <= -vn_reg;
            tn_reg  <= -tn_reg;
        end
    end

    assign det_ext  = ACCW'(det_reg);
    assign ndet     = -det_ext;
    assign cmp_fail = (cun_reg < ndet) || (cun_reg > clim_reg) || (cvn_reg < ndet)
                   || (cuv_reg > clim_reg) || (ctn_reg <= det_ext);

    assign status.reject   = (is_norm && (det_reg == '0)) || (is_cmp && cmp_fail);
    assign status.out_busy = out_valid_reg && !m_axis_tready;

    rtnh_div #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .VAL_W           (VW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .init  (cmd.exec && (cmd.uop.kind == UOP_DIV)),
        .step  (cmd.div_step),
        .num   (tn_reg),
        .den   (det_reg),
        .quot  (t_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg <= DIST_MAX;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            best_z_reg    <= '0;
            any_hit_reg   <= 1'b0;
        end
        else if (cmd.emit)
        begin
            best_dist_reg <= DIST_MAX;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            best_z_reg    <= '0;
            any_hit_reg   <= 1'b0;
        end
        else if (is_upd && (!any_hit_reg || (t_val < best_dist_reg)))
        begin
            best_dist_reg <= t_val;
            best_x_reg    <= hx_reg;
            best_y_reg    <= hy_reg;
            best_z_reg    <= hz_reg;
            any_hit_reg   <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_found_reg <= any_hit_reg;
            out_dist_reg  <= any_hit_reg ? best_dist_reg : '0;
            out_x_reg     <= any_hit_reg ? best_x_reg : '0;
            out_y_reg     <= any_hit_reg ? best_y_reg : '0;
            out_z_reg     <= any_hit_reg ? best_z_reg : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {1'b0, out_z_reg, out_y_reg, out_x_reg, out_dist_reg};

`ifndef SYNTHESIS
    a_best_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !any_hit_reg |-> best_dist_reg == DIST_MAX)
        else $error("kept distance not at maximum while no hit is held");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("result without hit carries nonzero fields");

    a_det_positive: assert property (@(posedge clk) disable iff (!rst_n)
        is_cmp |-> det_reg > 0)
        else $error("tolerance check on a non-positive determinant");
`endif

endmodule

`default_nettype wire

[test/ray_triangle_nearest_hit_tb.sv]
// Testbench for ray_triangle_nearest_hit: streams triangle meshes against programmed rays
// and checks every nearest-hit result against a fixed-point Moller-Trumbore predictor.
// Depends on rtnh_pkg and ray_triangle_nearest_hit.
`timescale 1ns / 100ps

module ray_triangle_nearest_hit_tb;
    import rtnh_pkg::*;

    localparam int FRAC = COORD_FRAC_BITS_DEF;
    localparam int ONE = 1 << FRAC;
    localparam int PHASE_ITEMS = 225;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [31:0] coord_t;
    typedef logic signed [DIR_W-1:0] dir_t;

    typedef struct packed {
        logic [8:0][31:0] corner;
        logic skip;
        logic last;
    } tri_t;

    typedef struct packed {
        logic found;
        logic [DIST_W-1:0] t_dist;
        coord_t hx;
        coord_t hy;
        coord_t hz;
    } hit_t;

    typedef struct {
        tri_t stim;
        bit typed;
        hit_t res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    ray_triangle_nearest_hit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    coord_t ray_org[3];
    dir_t ray_dir[3];
    logic [DIST_W-1:0] near_dist;
    coord_t near_pt[3];
    logic near_valid;

    hit_t pending_hits[$];
    int errors = 0;
    int requests = 0;
    int results = 0;
    int hits_seen = 0;
    bit sender_burst = 0;
    bit receiver_burst = 0;
    bit long_hold = 0;

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic coord_t sat_coord(input wide_t v);
        if (v > wide_t'(32'sh7FFFFFFF))
            return 32'sh7FFFFFFF;
        if (v < -wide_t'(64'sh80000000))
            return 32'sh80000000;
        return coord_t'(v);
    endfunction

    function automatic bit ray_meets(input tri_t t, output logic [DIST_W-1:0] t_dist);
        wide_t e1[3], e2[3], tv[3], dv[3], p[3], q[3];
        wide_t det, un, vn, tn, lim, num;
        int j, k;
        t_dist = '0;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = wide_t'(coord_t'(t.corner[3 + i])) - wide_t'(coord_t'(t.corner[i]));
            e2[i] = wide_t'(coord_t'(t.corner[6 + i])) - wide_t'(coord_t'(t.corner[i]));
            tv[i] = wide_t'(ray_org[i]) - wide_t'(coord_t'(t.corner[i]));
            dv[i] = wide_t'(ray_dir[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            p[i] = (dv[j] * e2[k] - dv[k] * e2[j]) >>> FRAC;
            q[i] = (tv[j] * e1[k] - tv[k] * e1[j]) >>> FRAC;
        end
        det = (e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2]) >>> FRAC;
        if (det == 0)
            return 0;
        un = (tv[0] * p[0] + tv[1] * p[1] + tv[2] * p[2]) >>> FRAC;
        vn = (dv[0] * q[0] + dv[1] * q[1] + dv[2] * q[2]) >>> FRAC;
        tn = (e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2]) >>> FRAC;
        if (det < 0)
        begin
            det = -det;
            un = -un;
            vn = -vn;
            tn = -tn;
        end
        lim = det * 10001;
        if (un * 10000 < -det || un * 10000 > lim)
            return 0;
        if (vn * 10000 < -det || (un + vn) * 10000 > lim)
            return 0;
        if (tn * 100000 <= det)
            return 0;
        num = tn <<< FRAC;
        if (num >= (det <<< 31))
            t_dist = DIST_MAX;
        else
            t_dist = DIST_W'(num / det);
        return 1;
    endfunction

    function automatic void track_nearest(input tri_t t);
        logic [DIST_W-1:0] d;
        hit_t r;
        if (!t.skip && ray_meets(t, d) && (!near_valid || d < near_dist))
        begin
            near_dist = d;
            near_valid = 1'b1;
            for (int i = 0; i < 3; i++)
                near_pt[i] = sat_coord(wide_t'(ray_org[i])
                    + ((wide_t'(ray_dir[i]) * wide_t'({1'b0, d})) >>> FRAC));
        end
        if (t.last)
        begin
            r = '0;
            if (near_valid)
                r = '{1'b1, near_dist, near_pt[0], near_pt[1], near_pt[2]};
            pending_hits.insert(pending_hits.size(), r);
            near_valid = 1'b0;
            near_dist = DIST_MAX;
            near_pt = '{0, 0, 0};
        end
    endfunction

    function automatic tri_t mk(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                input bit skip, input bit last);
        tri_t t;
        t.corner = {cz, cy, cx, bz, by, bx, az, ay, ax};
        t.skip = skip;
        t.last = last;
        return t;
    endfunction

    task automatic send_request(input tri_t t, input bit typed = 0, input hit_t want = '0);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= t.corner;
        s_axis_tuser <= t.skip;
        s_axis_tlast <= t.last;
        do @(posedge clk); while (!s_axis_tready);
        requests++;
        track_nearest(t);
        if (typed && t.last)
            pending_hits[pending_hits.size() - 1] = want;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z: ray_org[idx] = value;
            CFG_DIR_X, CFG_DIR_Y, CFG_DIR_Z: ray_dir[idx - CFG_DIR_X] = value[DIR_W-1:0];
            default: ;
        endcase
    endtask

    // wait out results and any triangle still being tested
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic load_ray(input int ox, oy, oz, dx, dy, dz);
        settle();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_DIR_X, dx);
        write_reg(CFG_DIR_Y, dy);
        write_reg(CFG_DIR_Z, dz);
        cfg_we <= 1'b0;
    endtask

    function automatic int rand_dir();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return $urandom_range(0, 1) ? ONE : -ONE;
            default: return int'($urandom_range(0, 2 * ONE)) - ONE;
        endcase
    endfunction

    function automatic tri_t random_tri(input bit last);
        tri_t t;
        longint hitp[3];
        longint t_par;
        int spread;
        int mode;
        mode = $urandom_range(0, 9);
        t_par = longint'($urandom_range(0, 300)) * ONE + $urandom_range(0, ONE - 1) - 20 * ONE;
        spread = $urandom_range(1, 60) * $urandom_range(1, ONE);
        for (int i = 0; i < 3; i++)
            hitp[i] = longint'(ray_org[i]) + ((longint'(ray_dir[i]) * t_par) >>> FRAC);
        for (int n = 0; n < 9; n++)
            case (mode)
                7: t.corner[n] = $urandom;
                8: t.corner[n] = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
                9: t.corner[n] = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
                default: t.corner[n] = 32'(hitp[n % 3]
                    + longint'(int'($urandom_range(0, 2 * spread)) - spread));
            endcase
        t.skip = ($urandom_range(0, 9) == 0);
        t.last = last || ($urandom_range(0, 5) == 0);
        return t;
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        hit_t got, want;
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = receiver_burst ? 0 : $urandom_range(0, 5);
            if (long_hold)
            begin
                stall = 3000;
                long_hold = 0;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got = '{m_axis_tuser[0], m_axis_tdata[30:0], m_axis_tdata[62:31],
                    m_axis_tdata[94:63], m_axis_tdata[126:95]};
            results++;
            if (pending_hits.size() == 0)
                report("unexpected result", got.t_dist, 0);
            else
            begin
                want = pending_hits.pop_front();
                hits_seen += want.found;
                if (got.found !== want.found) report("hit_found", got.found, want.found);
                if (got.t_dist !== want.t_dist) report("hit_distance", got.t_dist, want.t_dist);
                if (got.hx !== want.hx) report("hit_x", got.hx, want.hx);
                if (got.hy !== want.hy) report("hit_y", got.hy, want.hy);
                if (got.hz !== want.hz) report("hit_z", got.hz, want.hz);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("ray_triangle_nearest_hit verification failed");
        $finish;
    end

    initial
    begin
        row_t zero_ray[4];
        tri_t aimed[12];
        ray_org = '{0, 0, 0};
        ray_dir = '{0, 0, 0};
        near_valid = 1'b0;
        near_dist = DIST_MAX;
        near_pt = '{0, 0, 0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero direction after reset: nothing can be hit
        zero_ray[0] = '{mk('1 >>> 1, '1 >>> 1, '1 >>> 1, 32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF,
                           0, 0, 1), 1, '0};
        zero_ray[1] = '{mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                           32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 1, 1), 1, '0};
        zero_ray[2] = '{mk(-ONE, -ONE, 10 * ONE, ONE, -ONE, 10 * ONE, 0, ONE, 10 * ONE, 0, 0),
                        0, '0};
        zero_ray[3] = '{mk(32'h80000000, 0, 32'h7FFFFFFF, 0, 32'h80000000, 0, 32'h7FFFFFFF,
                           32'h7FFFFFFF, 32'h80000000, 0, 1), 1, '0};
        foreach (zero_ray[n])
            send_request(zero_ray[n].stim, zero_ray[n].typed, zero_ray[n].res);

        load_ray(0, 0, 0, 0, 0, ONE);
        aimed[0] = mk(-ONE, -ONE, 10 * ONE, ONE, -ONE, 10 * ONE, 0, ONE, 10 * ONE, 0, 0);
        aimed[1] = mk(-ONE, -ONE, 5 * ONE, ONE, -ONE, 5 * ONE, 0, ONE, 5 * ONE, 0, 1);
        aimed[2] = mk(-ONE, -ONE, 5 * ONE, ONE, ONE, 5 * ONE, 2 * ONE, 3 * ONE, 5 * ONE, 0, 1);
        aimed[3] = mk(-ONE, -ONE, -3 * ONE, ONE, -ONE, -3 * ONE, 0, ONE, -3 * ONE, 0, 1);
        aimed[4] = mk(4 * ONE, 4 * ONE, 7 * ONE, 6 * ONE, 4 * ONE, 7 * ONE, 5 * ONE, 6 * ONE,
                      7 * ONE, 0, 1);
        aimed[5] = mk(0, 0, 8 * ONE, 2 * ONE, 0, 8 * ONE, 0, 2 * ONE, 8 * ONE, 0, 1);
        aimed[6] = mk(-ONE, -ONE, 2 * ONE, ONE, -ONE, 2 * ONE, 0, ONE, 2 * ONE, 1, 0);
        aimed[7] = mk(-ONE, -ONE, 9 * ONE, ONE, -ONE, 9 * ONE, 0, ONE, 9 * ONE, 0, 0);
        aimed[8] = mk(-2 * ONE, -ONE, 9 * ONE, ONE, -ONE, 9 * ONE, 0, 2 * ONE, 9 * ONE, 0, 0);
        aimed[9] = mk(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE, 1, 1);
        aimed[10] = mk(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                       32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1);
        aimed[11] = mk(-ONE, -ONE, 1, ONE, -ONE, 1, 0, ONE, 1, 0, 1);
        foreach (aimed[n])
            send_request(aimed[n]);

        // register writes past the list must be ignored
        settle();
        write_reg(3'd6, 32'hFFFFFFFF);
        write_reg(3'd7, 32'h12345678);
        cfg_we <= 1'b0;
        for (int n = 0; n < 3; n++)
            send_request(random_tri(n == 2));

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: load_ray(32'h7FFFFFFF, 32'h80000000, 0, ONE, -ONE, ONE);
                1: load_ray(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, -ONE, ONE, -ONE);
                2: load_ray(0, 0, 0, 32'h1FFFF, 32'h20000, 32'h3FFFF);
                default: load_ray(int'($urandom_range(0, 200 * ONE)) - 100 * ONE,
                                  $urandom_range(0, 3) == 0 ? $urandom
                                      : int'($urandom_range(0, 200 * ONE)) - 100 * ONE,
                                  int'($urandom_range(0, 200 * ONE)) - 100 * ONE,
                                  rand_dir(), rand_dir(), rand_dir());
            endcase
            sender_burst = (phase == 4);
            receiver_burst = (phase == 5);
            long_hold = (phase == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 3 && n % 40 == 0)
                    sender_burst = !sender_burst;
                send_request(random_tri(n == PHASE_ITEMS - 1));
            end
        end

        settle();
        $display("Sent %0d triangle requests, checked %0d mesh results (%0d with a hit).",
                 requests, results, hits_seen);
        if (errors == 0)
            $display("ray_triangle_nearest_hit verification clean");
        else
            $display("ray_triangle_nearest_hit verification failed");
        $finish;
    end

endmodule
